@@ sv/fcn_pkg.sv @@
// Shared types, constants and helpers for the formula case normalizer.
// No dependencies; imported by the top level, the case unit and the checker.
`default_nettype none

package fcn_pkg;

    // Byte widths
    localparam int CHAR_W   = 8;
    localparam int LETTER_W = 7;

    // Default length of the kept part of a letter run
    localparam int MAX_RUN_DEF = 15;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'd40;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_FLUSH,
        S_TAIL
    } fcn_state_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                    ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

endpackage

`default_nettype wire

@@ sv/formula_case_normalizer.sv @@
// Results are registered onto m_axis from S_FLUSH or S_TAIL, after the item has left S_PROC.
// An item with no result goes from S_PROC back to S_IDLE; a passed character or terminator
// goes via S_TAIL; a run is flushed in S_FLUSH, one RAM read per cycle while m_axis is free.
// One item is in work at a time; s_axis_tready is high only while the sequencer is idle.
// Reset (rst_n, async, active low) clears the sequencer, count, gap flag and output valid;
// the letter buffer RAM is not cleared, entries are only read after being written.
`default_nettype none

module formula_case_normalizer
    import fcn_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // slave side
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] in_char
    input  wire logic              s_axis_tlast,   // end_of_text
    // master side
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [CHAR_W-1:0] m_axis_tdata,   // [7:0] out_char
    output logic                   m_axis_tlast,   // last_of_item
    output logic                   m_axis_tuser    // [0] end_mark
);

    localparam int CNT_W  = $clog2(MAX_RUN + 1);
    localparam int ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    fcn_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              gap_reg, gap_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              endt_reg, endt_next;

    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [LETTER_W-1:0] ram_rdata;
    logic [CHAR_W-1:0]   conv_char;

    logic s_accept;
    logic out_free;
    logic run_open;
    logic blank;
    logic letter_case;
    logic lower;
    logic last_idx;
    logic out_load;

    // Decode of the held item
    assign s_accept    = s_axis_tvalid && s_axis_tready;
    assign out_free    = !m_valid_reg || m_axis_tready;
    assign run_open    = (count_reg != '0);
    assign blank       = (char_reg == CH_SPACE) || (char_reg == CH_TAB);
    assign letter_case = !endt_reg && is_letter(char_reg);
    assign lower       = !endt_reg && (char_reg == CH_OPEN);
    assign last_idx    = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));

    // Letter buffer
    fcn_ram #(
        .WIDTH  (LETTER_W),
        .DEPTH  (MAX_RUN),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (char_reg[LETTER_W-1:0]),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    // Case conversion of the letter being flushed
    fcn_case_unit u_case (
        .letter   (ram_rdata),
        .lower    (lower),
        .out_char (conv_char)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (endt_reg)
                begin
                    state_next = run_open ? S_FLUSH : S_TAIL;
                end
                else if (blank)
                begin
                    state_next = S_IDLE;
                end
                else if (letter_case)
                begin
                    state_next = (run_open && gap_reg) ? S_FLUSH : S_IDLE;
                end
                else
                begin
                    state_next = run_open ? S_FLUSH : S_TAIL;
                end
            end
            S_FLUSH:
            begin
                if (out_free && last_idx)
                begin
                    state_next = letter_case ? S_IDLE : S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        s_axis_tready = 1'b0;
        count_next    = count_reg;
        gap_next      = gap_reg;
        idx_next      = idx_reg;
        char_next     = char_reg;
        endt_next     = endt_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[ADDR_W-1:0];
        out_load      = 1'b0;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_user_next   = m_user_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_accept)
                begin
                    char_next = s_axis_tdata;
                    endt_next = s_axis_tlast;
                end
            end
            S_PROC:
            begin
                idx_next = '0;
                if (!endt_reg)
                begin
                    if (blank)
                    begin
                        if (run_open)
                        begin
                            gap_next = 1'b1;
                        end
                    end
                    else if (letter_case)
                    begin
                        if (!run_open)
                        begin
                            // start a new run
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            count_next = CNT_W'(1);
                            gap_next   = 1'b0;
                        end
                        else if (!gap_reg && (count_reg < CNT_W'(MAX_RUN)))
                        begin
                            // append; letters past the limit are dropped
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    m_data_next = conv_char;
                    m_last_next = last_idx && letter_case;
                    m_user_next = 1'b0;
                    if (last_idx)
                    begin
                        idx_next = '0;
                        gap_next = 1'b0;
                        if (letter_case)
                        begin
                            // letter after a gap opens the next run
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            count_next = CNT_W'(1);
                        end
                        else
                        begin
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            S_TAIL:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    m_data_next = endt_reg ? CH_NUL : char_reg;
                    m_last_next = 1'b1;
                    m_user_next = endt_reg;
                    if (endt_reg)
                    begin
                        count_next = '0;
                        gap_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            gap_reg     <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            gap_reg     <= gap_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        endt_reg   <= endt_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

@@ sv/fcn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the letter run buffer.
`default_nettype none

module fcn_ram #(
    parameter int WIDTH  = 7,
    parameter int DEPTH  = 15,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/fcn_case_unit.sv @@
// Case converter shared by every flushed letter: forces a buffered
// letter to lower or upper case. Depends on fcn_pkg.
`default_nettype none

module fcn_case_unit
    import fcn_pkg::*;
(
    input  wire logic [LETTER_W-1:0] letter,
    input  wire logic                lower,
    output logic      [CHAR_W-1:0]   out_char
);

    logic [CHAR_W-1:0] c;

    assign c = {1'b0, letter};

    // Shift by the ASCII case offset where the letter has the other case
    always_comb
    begin
        out_char = c;
        if (lower)
        begin
            if ((c >= CH_UP_A) && (c <= CH_UP_Z))
            begin
                out_char = c + CASE_OFS;
            end
        end
        else
        begin
            if ((c >= CH_LO_A) && (c <= CH_LO_Z))
            begin
                out_char = c - CASE_OFS;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/fcn_checker.sv @@
// Port-level checks for formula_case_normalizer, bound to the top level.
// Depends on fcn_pkg and the top-level port list.
`default_nettype none

module fcn_checker
    import fcn_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [CHAR_W-1:0] s_axis_tdata,
    input wire logic              s_axis_tlast,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [CHAR_W-1:0] m_axis_tdata,
    input wire logic              m_axis_tlast,
    input wire logic              m_axis_tuser
);

    // Terminator always closes its item
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("end mark without last_of_item");

    // Terminator carries a zero byte
    a_end_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == CH_NUL))
        else $error("terminator byte not zero");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item taken while previous item in work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("output changed while stalled");

    // Waiting input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |=>
            (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast)))
        else $error("input changed while waiting");

endmodule

bind formula_case_normalizer fcn_checker u_fcn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
